@@ src/qpr_pkg.sv @@
// ============================================================================
// qpr_pkg
// Shared types and constants for the quaternion point rotation block.
// ============================================================================
package qpr_pkg;

    // Default field widths
    localparam int POINT_WIDTH_DEF = 24;
    localparam int QUAT_WIDTH_DEF  = 16;

    // Register stages from input accept to the output register
    localparam int NSTAGE = 5;

    // Configuration register index width
    localparam int CFG_IDX_W = 2;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } qpr_reg_t;

    // Per-stage load strobes from the pipeline control to the datapath
    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } qpr_ctrl_t;

endpackage

@@ src/qpr_datapath.sv @@
// ============================================================================
// qpr_datapath
// Five-stage arithmetic for r = q * (0,p) * conj(q), vector part, saturated.
// ============================================================================
module qpr_datapath #(
    parameter int POINT_WIDTH = qpr_pkg::POINT_WIDTH_DEF,
    parameter int QUAT_WIDTH  = qpr_pkg::QUAT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  qpr_pkg::qpr_ctrl_t            ctrl,
    input  logic signed [POINT_WIDTH-1:0] point_x,
    input  logic signed [POINT_WIDTH-1:0] point_y,
    input  logic signed [POINT_WIDTH-1:0] point_z,
    input  logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  quat_z,
    output logic signed [POINT_WIDTH-1:0] rotated_x,
    output logic signed [POINT_WIDTH-1:0] rotated_y,
    output logic signed [POINT_WIDTH-1:0] rotated_z,
    output logic                          saturated
);

    localparam int QF  = QUAT_WIDTH - 2;          // quaternion fraction bits
    localparam int PW1 = POINT_WIDTH + QUAT_WIDTH; // first products
    localparam int SW1 = PW1 + 2;                  // sum of three
    localparam int TW  = POINT_WIDTH + 4;          // intermediate quaternion t
    localparam int PW2 = TW + QUAT_WIDTH;          // second products
    localparam int SW2 = PW2 + 2;                  // sum of four
    localparam int RW  = SW2 - QF;                 // rounded result

    localparam logic signed [SW1-1:0] RND1 = {{(SW1-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
    localparam logic signed [SW2-1:0] RND2 = {{(SW2-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
    localparam logic signed [RW-1:0]  HI   = {{(RW-POINT_WIDTH+1){1'b0}}, {(POINT_WIDTH-1){1'b1}}};
    localparam logic signed [RW-1:0]  LO   = ~HI;

    // Stage 1: the twelve products of q * (0,p)
    logic signed [PW1-1:0] prod1_reg [12];
    // Stage 2: rounded t components
    logic signed [TW-1:0]  tx_reg, ty_reg, tz_reg, tw_reg;
    // Stage 3: the twelve products of t * conj(q)
    logic signed [PW2-1:0] prod2_reg [12];
    // Stage 4: rounded vector part
    logic signed [RW-1:0]  rx_reg, ry_reg, rz_reg;
    // Stage 5: clamped output
    logic signed [POINT_WIDTH-1:0] ox_reg, oy_reg, oz_reg;
    logic                          sat_reg;

    logic signed [SW1-1:0] s1x, s1y, s1z, s1w;
    logic signed [SW2-1:0] s2x, s2y, s2z;
    logic signed [TW-1:0]  tx_next, ty_next, tz_next, tw_next;
    logic signed [RW-1:0]  rx_next, ry_next, rz_next;
    logic signed [POINT_WIDTH-1:0] ox_next, oy_next, oz_next;
    logic                          sat_next;

    // Stage 1 products
    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            prod1_reg[0]  <= PW1'(point_x) * PW1'(quat_w);
            prod1_reg[1]  <= PW1'(point_z) * PW1'(quat_y);
            prod1_reg[2]  <= PW1'(point_y) * PW1'(quat_z);
            prod1_reg[3]  <= PW1'(point_y) * PW1'(quat_w);
            prod1_reg[4]  <= PW1'(point_x) * PW1'(quat_z);
            prod1_reg[5]  <= PW1'(point_z) * PW1'(quat_x);
            prod1_reg[6]  <= PW1'(point_z) * PW1'(quat_w);
            prod1_reg[7]  <= PW1'(point_y) * PW1'(quat_x);
            prod1_reg[8]  <= PW1'(point_x) * PW1'(quat_y);
            prod1_reg[9]  <= PW1'(point_x) * PW1'(quat_x);
            prod1_reg[10] <= PW1'(point_y) * PW1'(quat_y);
            prod1_reg[11] <= PW1'(point_z) * PW1'(quat_z);
        end
    end

    // Stage 2: sum, round half up, floor shift
    always_comb begin
        s1x = SW1'(prod1_reg[0]) + SW1'(prod1_reg[1]) - SW1'(prod1_reg[2]) + RND1;
        s1y = SW1'(prod1_reg[3]) + SW1'(prod1_reg[4]) - SW1'(prod1_reg[5]) + RND1;
        s1z = SW1'(prod1_reg[6]) + SW1'(prod1_reg[7]) - SW1'(prod1_reg[8]) + RND1;
        s1w = RND1 - SW1'(prod1_reg[9]) - SW1'(prod1_reg[10]) - SW1'(prod1_reg[11]);
        tx_next = TW'(s1x >>> QF);
        ty_next = TW'(s1y >>> QF);
        tz_next = TW'(s1z >>> QF);
        tw_next = TW'(s1w >>> QF);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            tx_reg <= tx_next;
            ty_reg <= ty_next;
            tz_reg <= tz_next;
            tw_reg <= tw_next;
        end
    end

    // Stage 3 products
    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            prod2_reg[0]  <= PW2'(tx_reg) * PW2'(quat_w);
            prod2_reg[1]  <= PW2'(tw_reg) * PW2'(quat_x);
            prod2_reg[2]  <= PW2'(ty_reg) * PW2'(quat_z);
            prod2_reg[3]  <= PW2'(tz_reg) * PW2'(quat_y);
            prod2_reg[4]  <= PW2'(ty_reg) * PW2'(quat_w);
            prod2_reg[5]  <= PW2'(tw_reg) * PW2'(quat_y);
            prod2_reg[6]  <= PW2'(tz_reg) * PW2'(quat_x);
            prod2_reg[7]  <= PW2'(tx_reg) * PW2'(quat_z);
            prod2_reg[8]  <= PW2'(tz_reg) * PW2'(quat_w);
            prod2_reg[9]  <= PW2'(tw_reg) * PW2'(quat_z);
            prod2_reg[10] <= PW2'(tx_reg) * PW2'(quat_y);
            prod2_reg[11] <= PW2'(ty_reg) * PW2'(quat_x);
        end
    end

    // Stage 4: sum, round
    always_comb begin
        s2x = SW2'(prod2_reg[0]) - SW2'(prod2_reg[1]) - SW2'(prod2_reg[2])
            + SW2'(prod2_reg[3]) + RND2;
        s2y = SW2'(prod2_reg[4]) - SW2'(prod2_reg[5]) - SW2'(prod2_reg[6])
            + SW2'(prod2_reg[7]) + RND2;
        s2z = SW2'(prod2_reg[8]) - SW2'(prod2_reg[9]) - SW2'(prod2_reg[10])
            + SW2'(prod2_reg[11]) + RND2;
        rx_next = RW'(s2x >>> QF);
        ry_next = RW'(s2y >>> QF);
        rz_next = RW'(s2z >>> QF);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
        end
    end

    // Stage 5: clamp to point range
    always_comb begin
        sat_next = 1'b0;
        if (rx_reg > HI) begin
            ox_next  = POINT_WIDTH'(HI);
            sat_next = 1'b1;
        end else if (rx_reg < LO) begin
            ox_next  = POINT_WIDTH'(LO);
            sat_next = 1'b1;
        end else begin
            ox_next = POINT_WIDTH'(rx_reg);
        end
        if (ry_reg > HI) begin
            oy_next  = POINT_WIDTH'(HI);
            sat_next = 1'b1;
        end else if (ry_reg < LO) begin
            oy_next  = POINT_WIDTH'(LO);
            sat_next = 1'b1;
        end else begin
            oy_next = POINT_WIDTH'(ry_reg);
        end
        if (rz_reg > HI) begin
            oz_next  = POINT_WIDTH'(HI);
            sat_next = 1'b1;
        end else if (rz_reg < LO) begin
            oz_next  = POINT_WIDTH'(LO);
            sat_next = 1'b1;
        end else begin
            oz_next = POINT_WIDTH'(rz_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            oz_reg  <= oz_next;
            sat_reg <= sat_next;
        end
    end

    assign rotated_x = ox_reg;
    assign rotated_y = oy_reg;
    assign rotated_z = oz_reg;
    assign saturated = sat_reg;

endmodule

@@ src/quaternion_point_rotate.sv @@
// An accepted point moves through the five stage registers in order, and
// m_tvalid rises once it reaches the last of them, the output register.
// One item per cycle unless the output stalls; each stage holds one item and
// moves on when the stage after it is empty or moving, so bubbles close up.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// identity quaternion into the configuration registers.
// ============================================================================
// quaternion_point_rotate
// Streams 3D points through a fixed-point rotation by a configured quaternion.
// ============================================================================
module quaternion_point_rotate #(
    parameter int POINT_WIDTH = qpr_pkg::POINT_WIDTH_DEF,
    parameter int QUAT_WIDTH  = qpr_pkg::QUAT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [QUAT_WIDTH-1:0]          cfg_data,
    // input points
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [((3*POINT_WIDTH+7)/8)*8-1:0] s_tdata, // point_x, point_y, point_z
    // rotated points
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [((3*POINT_WIDTH+7)/8)*8-1:0] m_tdata, // rotated_x, rotated_y, rotated_z
    output logic [0:0]                     m_tuser  // saturated
);

    localparam int NS = qpr_pkg::NSTAGE;
    localparam int DW = ((3*POINT_WIDTH+7)/8)*8;
    localparam int PW = POINT_WIDTH;
    localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = {2'b01, {(QUAT_WIDTH-2){1'b0}}};

    logic [QUAT_WIDTH-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic [NS-1:0]         valid_reg, valid_next;
    logic [NS-1:0]         rdy;
    qpr_pkg::qpr_ctrl_t    ctrl;
    logic signed [PW-1:0]  rot_x, rot_y, rot_z;
    logic                  sat;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_w_reg <= QUAT_ONE;
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
        end else if (cfg_valid) begin
            unique case (qpr_pkg::qpr_reg_t'(cfg_index))
                qpr_pkg::REG_QUAT_W: quat_w_reg <= cfg_data;
                qpr_pkg::REG_QUAT_X: quat_x_reg <= cfg_data;
                qpr_pkg::REG_QUAT_Y: quat_y_reg <= cfg_data;
                qpr_pkg::REG_QUAT_Z: quat_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage ready chain: a stage takes a new item when empty or emptying
    always_comb begin
        rdy[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    // Valid bits and load strobes
    always_comb begin
        valid_next    = valid_reg;
        ctrl.load[0]  = rdy[0] && s_tvalid;
        if (rdy[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NS; k++) begin
            ctrl.load[k] = rdy[k] && valid_reg[k-1];
            if (rdy[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NS-1];

    qpr_datapath #(
        .POINT_WIDTH (POINT_WIDTH),
        .QUAT_WIDTH  (QUAT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .point_x   (s_tdata[PW-1:0]),
        .point_y   (s_tdata[2*PW-1:PW]),
        .point_z   (s_tdata[3*PW-1:2*PW]),
        .quat_w    (quat_w_reg),
        .quat_x    (quat_x_reg),
        .quat_y    (quat_y_reg),
        .quat_z    (quat_z_reg),
        .rotated_x (rot_x),
        .rotated_y (rot_y),
        .rotated_z (rot_z),
        .saturated (sat)
    );

    // Output packing, zero fill above the three coordinates
    assign m_tdata    = DW'({rot_z, rot_y, rot_x});
    assign m_tuser[0] = sat;

    // A refused input means every stage is occupied
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg))
        else $error("input refused while a pipeline stage is empty");

    // An item in the last but one stage is held while the output stalls
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[NS-2] && valid_reg[NS-1] && !m_tready) |=> valid_reg[NS-2])
        else $error("item dropped behind a stalled output");

    // A saturated flag comes with at least one coordinate at a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (rot_x == {1'b0, {(PW-1){1'b1}}} || rot_x == {1'b1, {(PW-1){1'b0}}} ||
             rot_y == {1'b0, {(PW-1){1'b1}}} || rot_y == {1'b1, {(PW-1){1'b0}}} ||
             rot_z == {1'b0, {(PW-1){1'b1}}} || rot_z == {1'b1, {(PW-1){1'b0}}}))
        else $error("saturated flag without a clamped coordinate");

endmodule
